FILE: hdl/ordered_keyword_search_scorer_defines.svh
// assertion macros shared by the ordered keyword search scorer
// expects i_clk and the active-low synchronous reset i_rst_n in the using module
`ifndef ORDERED_KEYWORD_SEARCH_SCORER_DEFINES_SVH
`define ORDERED_KEYWORD_SEARCH_SCORER_DEFINES_SVH

// condition holds at every clock edge outside reset
`define OKSS_CHECK(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// trigger in a cycle implies the consequence in the next
`define OKSS_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/okss_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the ordered keyword search scorer
// no dependencies
package okss_pkg;

    localparam int PATTERN_MAX   = 56;
    localparam int SCORE_BITS    = 10;
    localparam int PATTERN_REGS  = (PATTERN_MAX + 7) / 8;
    localparam int PAT_SEL_BITS  = (PATTERN_REGS > 1) ? $clog2(PATTERN_REGS) : 1;
    localparam int IDX_BITS      = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LEN_BITS      = 6;
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 64;
    localparam int SCORE_MAX     = (1 << SCORE_BITS) - 1;
    localparam int COUNT_CAP     = SCORE_MAX + PATTERN_MAX;
    localparam int COUNT_BITS    = $clog2(COUNT_CAP + 1);

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_FIRST = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_LENGTH        = CFG_IDX_BITS'(PATTERN_REGS);

    localparam logic [7:0] SPACE_BYTE = 8'd32;
    localparam logic [8:0] FOLD_DIFF  = 9'd32;

    typedef logic [PATTERN_MAX-1:0][7:0] t_pat_bytes;

    // keyword first and last byte positions
    typedef struct packed {
        logic [PATTERN_MAX-1:0] st;
        logic [PATTERN_MAX-1:0] en;
    } t_kw_map;

    typedef struct packed {
        logic                done;
        logic [IDX_BITS-1:0] start;
        logic [IDX_BITS-1:0] last;
        logic [LEN_BITS-1:0] len;
        t_kw_map             rem;
    } t_kw_load;

    typedef struct packed {
        logic                  all_found;
        logic [SCORE_BITS-1:0] gap_score;
    } t_result;

endpackage

FILE: hdl/okss_in_if.sv
`timescale 1ns / 1ps
// subject byte channel, valid/ready handshake
// depends on okss_pkg
interface okss_in_if import okss_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] subject_byte;
    logic       end_of_string;

    modport source (output valid, output subject_byte, output end_of_string, input ready);
    modport sink   (input valid, input subject_byte, input end_of_string, output ready);
endinterface

FILE: hdl/okss_out_if.sv
`timescale 1ns / 1ps
// result channel, valid/ready handshake
// depends on okss_pkg
interface okss_out_if import okss_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  all_found;
    logic [SCORE_BITS-1:0] gap_score;

    modport source (output valid, output all_found, output gap_score, input ready);
    modport sink   (input valid, input all_found, input gap_score, output ready);
endinterface

FILE: hdl/ordered_keyword_search_scorer.sv
`timescale 1ns / 1ps
// ordered keyword search scorer, top level
// depends on okss_pkg, okss_in_if, okss_out_if, okss_cfg_regs, okss_search, okss_out_buf
//
//  channel   direction  payload                               handshake
//  i_word    in         subject_byte[7:0], end_of_string      valid/ready
//  o_word    out        all_found, gap_score[9:0]             valid/ready
//  i_cfg_*   in         i_cfg_idx[3:0], i_cfg_data[63:0]      i_cfg_we, no stall
//
// one word per cycle while ready is high; a byte is folded into the match vector in the
// cycle it is taken, and an end word's result is registered into the output buffer
// reset and each pattern or length register write force a reload with ready low
// results queue in a two-entry buffer; ready also drops while both entries are full
module ordered_keyword_search_scorer import okss_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    okss_in_if.sink                  i_word,
    okss_out_if.source               o_word
);

    logic       cfg_hit;
    t_pat_bytes pat;
    t_kw_map    map;
    logic       search_ready;
    logic       buf_full;
    logic       accept;
    logic       push;
    t_result    result;

    assign i_word.ready = search_ready && !buf_full;
    assign accept       = i_word.valid && i_word.ready;

    okss_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg_hit  (cfg_hit),
        .o_pat      (pat),
        .o_map      (map)
    );

    okss_search u_search (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_subject_byte  (i_word.subject_byte),
        .i_end_of_string (i_word.end_of_string),
        .i_cfg_hit       (cfg_hit),
        .i_pat           (pat),
        .i_map           (map),
        .o_ready         (search_ready),
        .o_push          (push),
        .o_result        (result)
    );

    okss_out_buf u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (result),
        .o_full   (buf_full),
        .o_word   (o_word)
    );

endmodule

FILE: hdl/okss_cfg_regs.sv
`timescale 1ns / 1ps
// pattern and length registers, plus the keyword start/end maps derived from them
// depends on okss_pkg
module okss_cfg_regs import okss_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output logic                     o_cfg_hit,
    output t_pat_bytes               o_pat,
    output t_kw_map                  o_map
);

    logic [PATTERN_REGS-1:0][CFG_DATA_BITS-1:0] r_pat_regs;
    logic [LEN_BITS-1:0]                        r_pat_len;
    logic [PATTERN_MAX-1:0]                     sp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_regs <= '0;
            r_pat_len  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx < REG_LENGTH) begin
                r_pat_regs[i_cfg_idx[PAT_SEL_BITS-1:0]] <= i_cfg_data;
            end else if (i_cfg_idx == REG_LENGTH) begin
                r_pat_len <= i_cfg_data[LEN_BITS-1:0];
            end
        end
    end

    assign o_cfg_hit = i_cfg_we && (i_cfg_idx <= REG_LENGTH);

    // a length past the buffer is clipped naturally: positions stop at PATTERN_MAX-1
    always_comb begin
        for (int j = 0; j < PATTERN_MAX; j++) begin
            o_pat[j] = r_pat_regs[j / 8][8 * (j % 8) +: 8];
            sp[j]    = (LEN_BITS'(j) >= r_pat_len) || (o_pat[j] == SPACE_BYTE);
        end
        for (int j = 0; j < PATTERN_MAX; j++) begin
            o_map.st[j] = !sp[j] && ((j == 0) || sp[(j > 0) ? j - 1 : 0]);
            o_map.en[j] = !sp[j] && ((j == PATTERN_MAX - 1) ||
                                     sp[(j < PATTERN_MAX - 1) ? j + 1 : j]);
        end
    end

endmodule

FILE: hdl/okss_kw_loader.sv
`timescale 1ns / 1ps
// picks the next keyword from the remaining start/end maps
// depends on okss_pkg
module okss_kw_loader import okss_pkg::*; (
    input  t_kw_map  i_src,
    output t_kw_load o_load
);

    logic [PATTERN_MAX-1:0] first_st;
    logic [PATTERN_MAX-1:0] first_en;
    logic [IDX_BITS-1:0]    start_idx;
    logic [IDX_BITS-1:0]    last_idx;

    function automatic logic [IDX_BITS-1:0] onehot_index(input logic [PATTERN_MAX-1:0] v);
        logic [IDX_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (v[i]) begin
                r = r | IDX_BITS'(i);
            end
        end
        return r;
    endfunction

    // lowest set bit, keywords pair up in order of position
    assign first_st  = i_src.st & (~i_src.st + 1'b1);
    assign first_en  = i_src.en & (~i_src.en + 1'b1);
    assign start_idx = onehot_index(first_st);
    assign last_idx  = onehot_index(first_en);

    always_comb begin
        o_load.done   = (i_src.st == '0);
        o_load.start  = start_idx;
        o_load.last   = last_idx;
        o_load.len    = LEN_BITS'(last_idx) - LEN_BITS'(start_idx) + 1'b1;
        o_load.rem.st = i_src.st & ~first_st;
        o_load.rem.en = i_src.en & ~first_en;
        if (o_load.done) begin
            o_load.start = '0;
            o_load.last  = '0;
            o_load.len   = LEN_BITS'(1);
        end
    end

endmodule

FILE: hdl/okss_search.sv
`timescale 1ns / 1ps
// per-byte keyword search: shift-and match vector, gap counter, score accumulator
// depends on okss_pkg, okss_kw_loader and the assertion macro header
`include "ordered_keyword_search_scorer_defines.svh"
module okss_search import okss_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_subject_byte,
    input  logic       i_end_of_string,
    input  logic       i_cfg_hit,
    input  t_pat_bytes i_pat,
    input  t_kw_map    i_map,
    output logic       o_ready,
    output logic       o_push,
    output t_result    o_result
);

    logic                   r_pending, n_pending;
    logic                   r_done, n_done;
    logic [IDX_BITS-1:0]    r_kw_start, n_kw_start;
    logic [IDX_BITS-1:0]    r_kw_end, n_kw_end;
    logic [LEN_BITS-1:0]    r_kw_len, n_kw_len;
    t_kw_map                r_rem, n_rem;
    logic [PATTERN_MAX-1:0] r_d, n_d;
    logic [COUNT_BITS-1:0]  r_count, n_count;
    logic [SCORE_BITS-1:0]  r_score, n_score;

    logic                   restart;
    logic                   byte_step;
    logic                   hit;
    t_kw_map                load_src;
    t_kw_load               load;
    logic [PATTERN_MAX-1:0] dn;
    logic [COUNT_BITS-1:0]  count_inc;
    logic [COUNT_BITS-1:0]  skipped;
    logic [SCORE_BITS-1:0]  skipped_sat;
    logic [SCORE_BITS:0]    score_sum;

    function automatic logic fold_eq(input logic [7:0] p, input logic [7:0] s);
        return (p == s) || ({1'b0, p} == ({1'b0, s} + FOLD_DIFF));
    endfunction

    assign restart   = r_pending || (i_accept && i_end_of_string);
    assign byte_step = i_accept && !i_end_of_string && !r_done && !r_pending;
    assign load_src  = restart ? i_map : r_rem;

    okss_kw_loader u_loader (
        .i_src  (load_src),
        .o_load (load)
    );

    // shift-and: bit j set means the keyword prefix ending at j matches the newest bytes
    always_comb begin
        for (int j = 0; j < PATTERN_MAX; j++) begin
            dn[j] = fold_eq(i_pat[j], i_subject_byte) &&
                    ((r_kw_start == IDX_BITS'(j)) || ((j > 0) && r_d[(j > 0) ? j - 1 : 0]));
        end
    end

    assign hit       = byte_step && dn[r_kw_end];
    assign count_inc = (r_count < COUNT_BITS'(COUNT_CAP)) ? r_count + 1'b1 : r_count;
    assign skipped   = count_inc - COUNT_BITS'(r_kw_len);
    assign skipped_sat = (skipped > COUNT_BITS'(SCORE_MAX)) ? SCORE_BITS'(SCORE_MAX)
                                                            : skipped[SCORE_BITS-1:0];
    assign score_sum = {1'b0, r_score} + {1'b0, skipped_sat};

    always_comb begin
        n_pending  = r_pending;
        n_done     = r_done;
        n_kw_start = r_kw_start;
        n_kw_end   = r_kw_end;
        n_kw_len   = r_kw_len;
        n_rem      = r_rem;
        n_d        = r_d;
        n_count    = r_count;
        n_score    = r_score;
        if (i_cfg_hit) begin
            // new pattern settles in the registers first, reload runs from the pending flag
            n_pending = 1'b1;
        end else if (restart) begin
            n_pending  = 1'b0;
            n_done     = load.done;
            n_kw_start = load.start;
            n_kw_end   = load.last;
            n_kw_len   = load.len;
            n_rem      = load.rem;
            n_d        = '0;
            n_count    = '0;
            n_score    = '0;
        end else if (byte_step) begin
            n_d     = dn;
            n_count = count_inc;
            if (hit) begin
                n_score    = score_sum[SCORE_BITS] ? SCORE_BITS'(SCORE_MAX)
                                                   : score_sum[SCORE_BITS-1:0];
                n_d        = '0;
                n_count    = '0;
                n_done     = load.done;
                n_kw_start = load.start;
                n_kw_end   = load.last;
                n_kw_len   = load.len;
                n_rem      = load.rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= 1'b1;
            r_done     <= 1'b1;
            r_kw_start <= '0;
            r_kw_end   <= '0;
            r_kw_len   <= LEN_BITS'(1);
            r_rem      <= '0;
            r_d        <= '0;
            r_count    <= '0;
            r_score    <= '0;
        end else begin
            r_pending  <= n_pending;
            r_done     <= n_done;
            r_kw_start <= n_kw_start;
            r_kw_end   <= n_kw_end;
            r_kw_len   <= n_kw_len;
            r_rem      <= n_rem;
            r_d        <= n_d;
            r_count    <= n_count;
            r_score    <= n_score;
        end
    end

    assign o_ready            = !r_pending;
    assign o_push             = i_accept && i_end_of_string;
    assign o_result.all_found = r_done;
    assign o_result.gap_score = r_done ? r_score : '0;

    `OKSS_CHECK(a_kw_len_nonzero, r_done || (r_kw_len != '0), "active keyword has zero length")
    `OKSS_CHECK(a_count_capped, r_count <= COUNT_BITS'(COUNT_CAP), "gap counter above cap")
    `OKSS_CHECK(a_kw_span, r_done || (r_kw_end == IDX_BITS'(r_kw_start + r_kw_len - 1'b1)), "keyword end inconsistent with start and length")
    `OKSS_NEXT(a_hit_clears, hit && !i_cfg_hit, (r_count == '0) && (r_d == '0), "match did not clear the search window")

endmodule

FILE: hdl/okss_out_buf.sv
`timescale 1ns / 1ps
// two-entry result buffer: output register plus skid slot
// depends on okss_pkg, okss_out_if
module okss_out_buf import okss_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_result           i_result,
    output logic              o_full,
    okss_out_if.source        o_word
);

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    out_fire;

    assign out_fire = r_out_valid && o_word.ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (out_fire) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || out_fire) begin
                n_out       = i_result;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_result;
                n_skid_valid = 1'b1;
            end
        end else if (out_fire) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full           = r_skid_valid;
    assign o_word.valid     = r_out_valid;
    assign o_word.all_found = r_out.all_found;
    assign o_word.gap_score = r_out.gap_score;

endmodule

FILE: tb/sv/ordered_keyword_search_scorer_tb.sv
`timescale 1ns / 1ps
// self-checking bench for ordered_keyword_search_scorer: writes search patterns, streams
// subject words, predicts each string's found flag and gap score, checks the result channel
// depends on okss_pkg, okss_in_if, okss_out_if and the scorer top level
module ordered_keyword_search_scorer_tb;
    import okss_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    typedef enum int {
        PAT_WORDS,
        PAT_FULL,
        PAT_OVERLONG,
        PAT_SPACES,
        PAT_BLANK,
        PAT_ODD,
        PAT_ONE_WORD
    } t_pat_kind;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } t_subj_word;

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     cfg_we     = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_idx    = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data   = '0;
    logic                     in_valid   = 1'b0;
    logic [7:0]               in_byte    = '0;
    logic                     in_eos     = 1'b0;
    logic                     rslt_ready = 1'b0;

    okss_in_if  in_ch ();
    okss_out_if out_ch ();

    assign in_ch.valid         = in_valid;
    assign in_ch.subject_byte  = in_byte;
    assign in_ch.end_of_string = in_eos;
    assign out_ch.ready        = rslt_ready;

    ordered_keyword_search_scorer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_word     (in_ch),
        .o_word     (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // search state as the scorer should hold it
    logic [CFG_DATA_BITS-1:0] pat_reg [PATTERN_REGS];
    logic [LEN_BITS-1:0]      pat_len;
    logic [7:0]               window [PATTERN_MAX];
    int                       win_fill;
    int                       kw_first;
    int                       kw_size;
    int                       since_match;
    int                       gap_total;
    bit                       kw_all_done;
    t_result                  awaited_scores [$];

    // stimulus state
    t_subj_word               subject_q [$];
    t_subj_word               next_word;
    logic [7:0]               pat_img [PATTERN_MAX];
    int                       img_len = 0;
    int                       img_span = 0;
    int                       kw_at [$];
    int                       kw_n [$];
    logic [CFG_IDX_BITS-1:0]  plan_idx [$];
    logic [CFG_DATA_BITS-1:0] plan_data [$];
    t_pat_kind                schedule [9] = '{PAT_WORDS, PAT_FULL, PAT_ODD,
                                               PAT_OVERLONG, PAT_WORDS, PAT_SPACES,
                                               PAT_ONE_WORD, PAT_BLANK, PAT_WORDS};
    int                       send_idle_pct = 15;
    int                       recv_idle_pct = 87;

    int                       words_queued = 0;
    int                       strings_sent = 0;
    int                       words_taken = 0;
    int                       results_seen = 0;
    int                       cfg_writes = 0;
    int                       err_count = 0;
    int                       cycle_count = 0;
    t_result                  want;

    function automatic int pattern_byte(int pos);
        if (pos >= PATTERN_MAX) return 0;
        return int'(pat_reg[pos / 8][8 * (pos % 8) +: 8]);
    endfunction

    function automatic void seek_keyword(int from);
        int pos;
        int span;
        span = (int'(pat_len) > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
        pos  = from;
        while (pos < span && pattern_byte(pos) == SPACE_BYTE) pos++;
        if (pos >= span) begin
            kw_all_done = 1'b1;
            kw_first    = 0;
            kw_size     = 0;
        end else begin
            kw_first = pos;
            while (pos < span && pattern_byte(pos) != SPACE_BYTE) pos++;
            kw_size = pos - kw_first;
        end
    endfunction

    function automatic void restart_search();
        foreach (window[i]) window[i] = 8'h00;
        win_fill    = 0;
        since_match = 0;
        gap_total   = 0;
        kw_all_done = 1'b0;
        seek_keyword(0);
    endfunction

    function automatic void load_pattern_reg(logic [CFG_IDX_BITS-1:0] idx,
                                             logic [CFG_DATA_BITS-1:0] data);
        if (idx < REG_LENGTH) begin
            pat_reg[idx - REG_PATTERN_FIRST] = data;
        end else if (idx == REG_LENGTH) begin
            pat_len = data[LEN_BITS-1:0];
        end else begin
            return;
        end
        restart_search();
    endfunction

    function automatic void score_word(logic [7:0] data, logic eos);
        t_result res;
        bit      hit;
        int      skipped;
        if (eos) begin
            res.all_found = kw_all_done;
            res.gap_score = kw_all_done ? SCORE_BITS'(gap_total) : '0;
            awaited_scores.push_back(res);
            restart_search();
            return;
        end
        // bytes after the last keyword change nothing
        if (kw_all_done) return;
        for (int i = PATTERN_MAX - 1; i > 0; i--) window[i] = window[i - 1];
        window[0] = data;
        if (win_fill < PATTERN_MAX) win_fill++;
        if (since_match < COUNT_CAP) since_match++;
        hit = (kw_size != 0) && (win_fill >= kw_size);
        for (int k = 0; k < kw_size && hit; k++) begin
            if (pattern_byte(kw_first + k) != int'(window[kw_size - 1 - k]) &&
                pattern_byte(kw_first + k) != int'(window[kw_size - 1 - k]) + int'(FOLD_DIFF))
                hit = 1'b0;
        end
        if (hit) begin
            skipped = since_match - kw_size;
            if (skipped > SCORE_MAX) skipped = SCORE_MAX;
            gap_total = gap_total + skipped;
            if (gap_total > SCORE_MAX) gap_total = SCORE_MAX;
            win_fill    = 0;
            since_match = 0;
            seek_keyword(kw_first + kw_size);
        end
    endfunction

    function automatic void put_word(logic [7:0] data, logic eos);
        subject_q.push_back('{data, eos});
        words_queued++;
    endfunction

    // a byte of the current pattern, sometimes case folded, or plain noise
    function automatic logic [7:0] near_byte();
        logic [7:0] b;
        if (img_span == 0 || $urandom_range(4) < 2) return 8'($urandom);
        b = pat_img[$urandom_range(0, img_span - 1)];
        if (b >= SPACE_BYTE && $urandom_range(1) == 1) b = b - 8'(FOLD_DIFF);
        return b;
    endfunction

    // splits pat_img into keywords for stimulus and stages the register writes
    function automatic void stage_pattern();
        int                       pos;
        int                       at;
        logic [CFG_DATA_BITS-1:0] data;
        img_span = (img_len > PATTERN_MAX) ? PATTERN_MAX : img_len;
        kw_at.delete();
        kw_n.delete();
        pos = 0;
        while (pos < img_span) begin
            if (pat_img[pos] == SPACE_BYTE) begin
                pos++;
            end else begin
                kw_at.push_back(pos);
                while (pos < img_span && pat_img[pos] != SPACE_BYTE) pos++;
                kw_n.push_back(pos - kw_at[$]);
            end
        end
        for (int r = 0; r < PATTERN_REGS; r++) begin
            for (int b = 0; b < 8; b++) data[8 * b +: 8] = pat_img[8 * r + b];
            plan_idx.push_back(CFG_IDX_BITS'(int'(REG_PATTERN_FIRST) + r));
            plan_data.push_back(data);
        end
        data = {$urandom, $urandom};
        data[LEN_BITS-1:0] = LEN_BITS'(img_len);
        plan_idx.push_back(REG_LENGTH);
        plan_data.push_back(data);
        // now and then a write to an unused index somewhere in the sequence
        if ($urandom_range(1) == 1) begin
            at = $urandom_range(0, plan_idx.size());
            plan_idx.insert(at, CFG_IDX_BITS'($urandom_range(int'(REG_LENGTH) + 1,
                                                             (1 << CFG_IDX_BITS) - 1)));
            plan_data.insert(at, {$urandom, $urandom});
        end
    endfunction

    function automatic void build_pattern(t_pat_kind kind);
        foreach (pat_img[i]) pat_img[i] = 8'($urandom);
        case (kind)
            PAT_BLANK:    img_len = 0;
            PAT_FULL:     img_len = PATTERN_MAX;
            PAT_OVERLONG: img_len = $urandom_range(PATTERN_MAX + 1, (1 << LEN_BITS) - 1);
            PAT_ONE_WORD: img_len = $urandom_range(PATTERN_MAX - 8, PATTERN_MAX);
            default:      img_len = $urandom_range(1, PATTERN_MAX);
        endcase
        for (int i = 0; i < PATTERN_MAX && i < img_len; i++) begin
            case (kind)
                PAT_SPACES: begin
                    pat_img[i] = SPACE_BYTE;
                end
                PAT_ODD: begin
                    case ($urandom_range(7))
                        0:       pat_img[i] = 8'h00;
                        1:       pat_img[i] = 8'h1F;
                        2:       pat_img[i] = SPACE_BYTE;
                        3:       pat_img[i] = 8'h80;
                        4:       pat_img[i] = 8'hDF;
                        5:       pat_img[i] = 8'hFF;
                        6:       pat_img[i] = 8'hE0;
                        default: pat_img[i] = 8'($urandom);
                    endcase
                end
                default: begin
                    case ($urandom_range(7))
                        0:       pat_img[i] = "a";
                        1:       pat_img[i] = "A";
                        2:       pat_img[i] = "b";
                        3:       pat_img[i] = "B";
                        4:       pat_img[i] = "c";
                        5:       pat_img[i] = 8'h00;
                        6:       pat_img[i] = 8'hFF;
                        default: pat_img[i] = "z";
                    endcase
                    if (kind != PAT_ONE_WORD && $urandom_range(3) == 0) pat_img[i] = SPACE_BYTE;
                end
            endcase
        end
        stage_pattern();
    endfunction

    // mostly well-formed strings: filler, then each keyword in order, folded at random
    function automatic void queue_string();
        int         gap;
        bit         broken;
        logic [7:0] b;
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(0, 12)) put_word(8'($urandom), 1'b0);
        end else begin
            foreach (kw_at[i]) begin
                if ($urandom_range(3) == 0) gap = $urandom_range(3, 12);
                else gap = $urandom_range(0, 2);
                repeat (gap) put_word(near_byte(), 1'b0);
                broken = ($urandom_range(11) == 0);
                for (int k = 0; k < kw_n[i]; k++) begin
                    b = pat_img[kw_at[i] + k];
                    if (b >= SPACE_BYTE && $urandom_range(1) == 1) b = b - 8'(FOLD_DIFF);
                    if (broken && k == kw_n[i] - 1) b = b ^ 8'h04;
                    put_word(b, 1'b0);
                end
            end
            repeat ($urandom_range(0, 3)) put_word(near_byte(), 1'b0);
        end
        put_word(8'($urandom), 1'b1);
        strings_sent++;
    endfunction

    task automatic wait_idle();
        while (subject_q.size() != 0 || in_valid || awaited_scores.size() != 0)
            @(posedge i_clk);
        // a byte word may still be in flight with nothing expected
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_plan();
        while (plan_idx.size() != 0) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= plan_idx.pop_front();
            cfg_data <= plan_data.pop_front();
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    // word driver; also tracks register writes and accepted words in the predictor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            foreach (pat_reg[i]) pat_reg[i] = '0;
            pat_len = '0;
            restart_search();
        end else begin
            if (cfg_we) begin
                cfg_writes++;
                load_pattern_reg(cfg_idx, cfg_data);
            end
            if (in_valid && in_ch.ready) begin
                words_taken++;
                score_word(in_byte, in_eos);
            end
            if (!in_valid || in_ch.ready) begin
                if (subject_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_word = subject_q.pop_front();
                    in_valid <= 1'b1;
                    in_byte  <= next_word.data;
                    in_eos   <= next_word.eos;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rslt_ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (awaited_scores.size() == 0) begin
                    err_count++;
                    $display("%0t: result with none expected, actual all_found=%0d gap_score=%0d",
                             $time, out_ch.all_found, out_ch.gap_score);
                end else begin
                    want = awaited_scores.pop_front();
                    if (out_ch.all_found !== want.all_found) begin
                        err_count++;
                        $display("%0t: all_found expected %0d actual %0d",
                                 $time, want.all_found, out_ch.all_found);
                    end
                    if (out_ch.gap_score !== want.gap_score) begin
                        err_count++;
                        $display("%0t: gap_score expected %0d actual %0d",
                                 $time, want.gap_score, out_ch.gap_score);
                    end
                end
            end
            rslt_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still awaited", $time, awaited_scores.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int first_word;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // blank pattern out of reset: always found, score zero
        put_word("A", 1'b0);
        put_word(8'h00, 1'b1);
        put_word(8'hA5, 1'b1);
        wait_idle();

        // keywords "ab", zero byte then 0xff, "x", with extra spaces
        foreach (pat_img[i]) pat_img[i] = 8'($urandom);
        pat_img[0] = "a";
        pat_img[1] = "b";
        pat_img[2] = SPACE_BYTE;
        pat_img[3] = 8'h00;
        pat_img[4] = 8'hFF;
        pat_img[5] = SPACE_BYTE;
        pat_img[6] = SPACE_BYTE;
        pat_img[7] = "x";
        img_len    = 8;
        stage_pattern();
        write_plan();
        // folded match, one skipped byte, high byte folded, trailing byte ignored
        put_word("A", 1'b0);
        put_word("b", 1'b0);
        put_word(8'h55, 1'b0);
        put_word(8'h00, 1'b0);
        put_word(8'hDF, 1'b0);
        put_word("x", 1'b0);
        put_word(8'h99, 1'b0);
        put_word(8'h00, 1'b1);
        // second keyword missing
        put_word("a", 1'b0);
        put_word("b", 1'b0);
        put_word(8'h00, 1'b1);
        put_word(8'h00, 1'b0);
        put_word(8'hFF, 1'b0);
        put_word("a", 1'b0);
        put_word("b", 1'b0);
        put_word(8'h00, 1'b1);
        // pattern rewritten in the middle of a string
        put_word("a", 1'b0);
        wait_idle();

        // low pattern byte must not match a high subject byte through wrap
        foreach (pat_img[i]) pat_img[i] = 8'($urandom);
        pat_img[0] = 8'h10;
        pat_img[1] = SPACE_BYTE;
        pat_img[2] = 8'h7F;
        img_len    = 3;
        stage_pattern();
        write_plan();
        put_word(8'hF0, 1'b0);
        put_word(8'h10, 1'b0);
        put_word(8'h5F, 1'b0);
        put_word(8'h00, 1'b1);

        foreach (schedule[c]) begin
            if (c == 3) begin
                send_idle_pct = 87;
                recv_idle_pct = 15;
            end
            if (c == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // sometimes leave a string unfinished across the pattern change
            if ($urandom_range(1) == 1) begin
                repeat ($urandom_range(1, 5)) put_word(near_byte(), 1'b0);
            end
            wait_idle();
            build_pattern(schedule[c]);
            write_plan();
            first_word = words_queued;
            for (int n = 0; n < 6 && (n < 1 || words_queued - first_word < 40); n++) begin
                if (n == 3) begin
                    // hold the sender mid-string until every result is back
                    repeat ($urandom_range(1, 3)) put_word(near_byte(), 1'b0);
                    wait_idle();
                end
                queue_string();
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("covered %0d subject words in %0d strings, %0d register writes, 11 patterns",
                 words_taken, strings_sent, cfg_writes);
        $display("%0d results checked, %0d mismatches", results_seen, err_count);
        if (err_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/okss_pkg.sv
hdl/okss_in_if.sv
hdl/okss_out_if.sv
hdl/okss_cfg_regs.sv
hdl/okss_kw_loader.sv
hdl/okss_search.sv
hdl/okss_out_buf.sv
hdl/ordered_keyword_search_scorer.sv
tb/sv/ordered_keyword_search_scorer_tb.sv
